>>> design/sacl_pkg.sv
// Package for the set-associative cache tag lookup.
// Holds the default geometry, the sequencer state type and the scan control word.
// No dependencies.
package sacl_pkg;

  localparam int DEF_BLOCK_BYTES = 64;
  localparam int DEF_SET_COUNT   = 512;
  localparam int DEF_WAY_COUNT   = 4;
  localparam int DEF_ADDR_BITS   = 48;

  localparam int TIME_W  = 32;
  localparam int COUNT_W = 32;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } state_t;

  typedef struct packed {
    logic start;
    logic valid;
  } scan_ctl_t;

endpackage

>>> design/sacl_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sacl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> design/sacl_way_scan.sv
// Way scan unit: one tag compare and one victim compare per cycle over the ways of a set.
// Records the hit way, the first invalid way and the replacement victim.
// Depends on sacl_pkg.
module sacl_way_scan
  import sacl_pkg::*;
#(
  parameter int TAG_W = 33,
  parameter int WAY_W = 2
) (
  input  logic                            clk,
  input  scan_ctl_t                       ctl,
  input  logic [WAY_W-1:0]                way,
  input  logic [TAG_W+TIME_W+COUNT_W+1:0] rline,
  input  logic                            mode,
  input  logic [TAG_W-1:0]                req_tag,
  output logic                            hit_found,
  output logic [WAY_W-1:0]                hit_way,
  output logic [TAG_W+TIME_W+COUNT_W+1:0] hit_line,
  output logic                            inv_found,
  output logic [WAY_W-1:0]                inv_way,
  output logic [WAY_W-1:0]                vic_way,
  output logic [TAG_W+TIME_W+COUNT_W+1:0] vic_line
);

  localparam int TOUCH_LO = COUNT_W;
  localparam int TAG_LO   = COUNT_W + TIME_W;
  localparam int VALID_B  = TAG_W + TIME_W + COUNT_W + 1;

  logic               r_valid;
  logic [TAG_W-1:0]   r_tag;
  logic [TIME_W-1:0]  r_touch;
  logic [COUNT_W-1:0] r_count;
  logic [TIME_W-1:0]  v_touch;
  logic [COUNT_W-1:0] v_count;
  logic               better;

  assign r_valid = rline[VALID_B];
  assign r_tag   = rline[TAG_LO +: TAG_W];
  assign r_touch = rline[TOUCH_LO +: TIME_W];
  assign r_count = rline[COUNT_W-1:0];
  assign v_touch = vic_line[TOUCH_LO +: TIME_W];
  assign v_count = vic_line[COUNT_W-1:0];
  assign better  = mode ? (r_touch < v_touch) : (r_count < v_count);

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      hit_found <= 1'b0;
      inv_found <= 1'b0;
    end else if (ctl.valid) begin
      if (r_valid && (r_tag == req_tag) && !hit_found) begin
        hit_found <= 1'b1;
        hit_way   <= way;
        hit_line  <= rline;
      end
      if (!r_valid && !inv_found) begin
        inv_found <= 1'b1;
        inv_way   <= way;
      end
      if ((way == '0) || better) begin
        vic_way  <= way;
        vic_line <= rline;
      end
    end
  end

endmodule

>>> design/set_assoc_cache_tag_lookup_top.sv
// Top level of the set-associative cache tag lookup with LFU or LRU replacement.
// Sequencer, request and result registers, line store; uses sacl_ram and sacl_way_scan.
// Depends on sacl_pkg.
//
//   channel  signals                                         direction
//   in       in_valid/in_ready, opcode, address, touch_stamp  into block
//   out      out_valid/out_ready, hit, writeback_needed,      out of block
//            writeback_address, victim_was_dirty
//   cfg      cfg_write_en, cfg_write_data (replacement_mode)  into block
//
// Each word passes through these steps: accept, one line store read per way plus the
// last compare through the shared scan unit, then one update write.
// After reset a clearing pass writes every line invalid, one entry per cycle over
// SET_COUNT sets of 2**WAY_W slots; in_ready stays low meanwhile. A result waits in the
// output register; the update holds while that register is full and out_ready is low.
module set_assoc_cache_tag_lookup_top
  import sacl_pkg::*;
#(
  parameter int BLOCK_BYTES = DEF_BLOCK_BYTES,
  parameter int SET_COUNT   = DEF_SET_COUNT,
  parameter int WAY_COUNT   = DEF_WAY_COUNT,
  parameter int ADDR_BITS   = DEF_ADDR_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write_en,
  input  logic                 cfg_write_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 opcode,
  input  logic [ADDR_BITS-1:0] address,
  input  logic [TIME_W-1:0]    touch_stamp,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 hit,
  output logic                 writeback_needed,
  output logic [ADDR_BITS-1:0] writeback_address,
  output logic                 victim_was_dirty
);

  localparam int OFF_W   = $clog2(BLOCK_BYTES);
  localparam int SET_W   = $clog2(SET_COUNT);
  localparam int WAY_W   = (WAY_COUNT > 1) ? $clog2(WAY_COUNT) : 1;
  localparam int TAG_W   = ADDR_BITS - OFF_W - SET_W;
  localparam int LINE_W  = TAG_W + TIME_W + COUNT_W + 2;
  localparam int IDX_W   = SET_W + WAY_W;
  localparam int DEPTH   = SET_COUNT * (1 << WAY_W);
  localparam int TAG_LO   = COUNT_W + TIME_W;
  localparam int DIRTY_B  = TAG_W + TIME_W + COUNT_W;

  state_t state, state_next;

  logic               replacement_mode;
  logic               req_store;
  logic [TAG_W-1:0]   req_tag;
  logic [SET_W-1:0]   req_set;
  logic [TIME_W-1:0]  req_time;
  logic [WAY_W:0]     iss;
  logic               cmp_vld;
  logic [WAY_W-1:0]   cmp_way;
  logic [IDX_W-1:0]   clr_idx;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [LINE_W-1:0]  ram_wdata;
  logic               ram_re;
  logic [IDX_W-1:0]   ram_raddr;
  logic [LINE_W-1:0]  ram_rdata;

  scan_ctl_t          scan_ctl;
  logic               hit_found;
  logic [WAY_W-1:0]   hit_way;
  logic [LINE_W-1:0]  hit_line;
  logic               inv_found;
  logic [WAY_W-1:0]   inv_way;
  logic [WAY_W-1:0]   vic_way;
  logic [LINE_W-1:0]  vic_line;

  logic               in_fire;
  logic               upd_fire;
  logic               iss_live;
  logic               scan_last;
  logic [COUNT_W-1:0] hit_count;
  logic [COUNT_W-1:0] hit_count_inc;
  logic [WAY_W-1:0]   upd_way;
  logic [LINE_W-1:0]  upd_line;
  logic               evict;

  assign in_fire   = in_valid && in_ready;
  assign upd_fire  = (state == ST_UPDATE) && (!out_valid || out_ready);
  assign iss_live  = iss < (WAY_W + 1)'(WAY_COUNT);
  assign scan_last = cmp_vld && (cmp_way == WAY_W'(WAY_COUNT - 1));

  sacl_ram #(
    .WIDTH(LINE_W),
    .DEPTH(DEPTH)
  ) u_lines (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  sacl_way_scan #(
    .TAG_W(TAG_W),
    .WAY_W(WAY_W)
  ) u_scan (
    .clk      (clk),
    .ctl      (scan_ctl),
    .way      (cmp_way),
    .rline    (ram_rdata),
    .mode     (replacement_mode),
    .req_tag  (req_tag),
    .hit_found(hit_found),
    .hit_way  (hit_way),
    .hit_line (hit_line),
    .inv_found(inv_found),
    .inv_way  (inv_way),
    .vic_way  (vic_way),
    .vic_line (vic_line)
  );

  // Update word
  assign hit_count     = hit_line[COUNT_W-1:0];
  assign hit_count_inc = (hit_count == '1) ? hit_count : hit_count + COUNT_W'(1);
  assign evict         = !hit_found && !inv_found;

  always_comb begin
    priority if (hit_found) begin
      upd_way  = hit_way;
      upd_line = {1'b1, hit_line[DIRTY_B] | req_store, req_tag, req_time, hit_count_inc};
    end else if (inv_found) begin
      upd_way  = inv_way;
      upd_line = {1'b1, req_store, req_tag, req_time, COUNT_W'(1)};
    end else begin
      upd_way  = vic_way;
      upd_line = {1'b1, req_store, req_tag, req_time, COUNT_W'(1)};
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_idx == '1) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (upd_fire) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_ready       = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = {req_set, upd_way};
    ram_wdata      = upd_line;
    ram_re         = 1'b0;
    ram_raddr      = {req_set, iss[WAY_W-1:0]};
    scan_ctl.start = 1'b0;
    scan_ctl.valid = cmp_vld;
    unique case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_idx;
        ram_wdata = '0;
      end
      ST_IDLE: begin
        in_ready       = 1'b1;
        scan_ctl.start = 1'b1;
      end
      ST_SCAN: begin
        ram_re = iss_live;
      end
      ST_UPDATE: begin
        ram_we = upd_fire;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_CLEAR;
      replacement_mode <= 1'b0;
      clr_idx          <= '0;
      iss              <= '0;
      cmp_vld          <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write_en) begin
        replacement_mode <= cfg_write_data;
      end
      if (state == ST_CLEAR) begin
        clr_idx <= clr_idx + IDX_W'(1);
      end
      if (in_fire) begin
        iss <= '0;
      end else if ((state == ST_SCAN) && iss_live) begin
        iss <= iss + (WAY_W + 1)'(1);
      end
      cmp_vld <= (state == ST_SCAN) && iss_live;
      if (upd_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmp_way <= iss[WAY_W-1:0];
    if (in_fire) begin
      req_store <= opcode;
      req_tag   <= address[ADDR_BITS-1 -: TAG_W];
      req_set   <= address[OFF_W +: SET_W];
      req_time  <= touch_stamp;
    end
    if (upd_fire) begin
      hit              <= hit_found;
      writeback_needed <= evict;
      victim_was_dirty <= evict && vic_line[DIRTY_B];
      writeback_address <= evict ? {vic_line[TAG_LO +: TAG_W], req_set, OFF_W'(0)}
                                 : '0;
    end
  end

  a_hit_no_wb: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(hit && writeback_needed))
    else $error("write-back reported on a hit");

  a_no_wb_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !writeback_needed) |-> (!victim_was_dirty && (writeback_address == '0)))
    else $error("write-back fields set without an eviction");

  a_rw_excl: assert property (@(posedge clk) disable iff (rst)
    ram_re |-> !ram_we)
    else $error("line store read and written in one cycle");

  a_accept_scan: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> (state == ST_SCAN) && (iss == '0))
    else $error("accepted word did not start a set scan");

  a_cmp_in_scan: assert property (@(posedge clk) disable iff (rst)
    cmp_vld |-> (state == ST_SCAN))
    else $error("compare outside of a set scan");

endmodule
